### design/distance_constraint_projection_core_defines.svh
// assertion macros used by the checker file
`ifndef DISTANCE_CONSTRAINT_PROJECTION_CORE_DEFINES_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcp assertion failed");

// next-cycle implication, disabled in reset
`define DCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcp assertion failed");

`endif

### design/dcp_pkg.sv
// types and constants of the distance constraint projection core
`timescale 1ns / 1ps

package dcp_pkg;

  // particle and link index ranges, ids wrap modulo these
  localparam int MaxParticles = 4096;
  localparam int MaxLinks     = 8192;

  // stiffness after reset, 0.3 in Q0.16
  localparam logic [15:0] StiffReset = 16'd19661;

  // stage map of the pipeline
  localparam int StDiff     = 1;
  localparam int StAbs      = 2;
  localparam int StSquare   = 3;
  localparam int StRad      = 4;
  localparam int StRoot0    = 5;
  localparam int RootSteps  = 33;
  localparam int StRatio0   = 5;
  localparam int RatioSteps = 17;
  localparam int StGain     = StRatio0 + RatioSteps;
  localparam int StErr      = StRoot0 + RootSteps;
  localparam int StNorm0    = StErr + 1;
  localparam int NormSteps  = 31;
  localparam int StMass     = StErr + 1;
  localparam int StProd     = StNorm0 + NormSteps;
  localparam int StRound    = StProd + 1;
  localparam int StPack     = StRound + 1;
  localparam int NumStages  = StPack + 1;

  // beat widths
  localparam int InDataW  = 264;
  localparam int OutDataW = 168;

  // everything one link carries down the pipeline
  typedef struct packed {
    logic [12:0] link;
    logic [11:0] ida;
    logic [11:0] idb;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] rest;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] sum;
    logic        xneg;
    logic        yneg;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [65:0] rad;
    logic [35:0] rem;
    logic [32:0] root;
    logic [48:0] nr1;
    logic [48:0] nr2;
    logic [16:0] r1;
    logic [16:0] r2;
    logic [16:0] g1;
    logic [16:0] g2;
    logic        eneg;
    logic [32:0] emag;
    logic        deg;
    logic [62:0] nx;
    logic [62:0] ny;
    logic [30:0] qx;
    logic [30:0] qy;
    logic [33:0] ma;
    logic [33:0] mb;
    logic [47:0] pal_x;
    logic [47:0] pah_x;
    logic [47:0] pal_y;
    logic [47:0] pah_y;
    logic [47:0] pbl_x;
    logic [47:0] pbh_x;
    logic [47:0] pbl_y;
    logic [47:0] pbh_y;
    logic [35:0] mag_ax;
    logic [35:0] mag_ay;
    logic [35:0] mag_bx;
    logic [35:0] mag_by;
    logic [31:0] sax;
    logic [31:0] say;
    logic [31:0] sbx;
    logic [31:0] sby;
  } pipe_t;

  // one finished result beat
  typedef struct packed {
    logic                deg;
    logic [OutDataW-1:0] data;
  } res_t;

endpackage

### design/distance_constraint_projection_core.sv
// distance constraint projection core: pipelined link solver with output skid
`timescale 1ns / 1ps

// Takes one link per beat on the slave stream and returns one correction beat per link on the
// master stream, in order. A new link is accepted every cycle while the output side keeps up;
// the pipeline depth is set by the 33-step square root of the squared distance followed by the
// 31-step restoring divide that forms the unit direction, one step per pipeline stage. A two-entry
// output register and skid stage decouple the sides, so s_axis_tready_o only drops once a result
// waits in the skid entry. Corrections are Q16.16, rounded half up on magnitudes and saturated to
// 32 bits; coincident particles or a zero inverse-mass sum give zero corrections and the degenerate
// flag. The stiffness register is written through stiff_we_i; the user writes it only while the
// core is idle, and the core itself does not enforce this.
module distance_constraint_projection_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stiffness register, unsigned Q0.16
  input  logic                          stiff_we_i,
  input  logic [15:0]                   stiff_wdata_i,
  // link beat
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // link_index, first_id, second_id, first_x, first_y, second_x, second_y,
  // first_inv_mass, second_inv_mass, rest_length, zero pad
  input  logic [dcp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // correction beat
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // done_link, target_a, shift_a_x, shift_a_y, target_b, shift_b_x, shift_b_y, zero pad
  output logic [dcp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // degenerate
  output logic [0:0]                    m_axis_tuser_o
);

  localparam int NS = dcp_pkg::NumStages;

  logic [15:0]     stiff_q;
  dcp_pkg::pipe_t  pipe_q [NS];
  dcp_pkg::pipe_t  pipe_d [NS];
  logic [NS-1:0]   vld_q;
  logic            en;
  dcp_pkg::res_t   last_res;
  dcp_pkg::res_t   out_q;
  dcp_pkg::res_t   skid_q;
  logic            out_vld_q;
  logic            skid_vld_q;
  logic            push;
  logic            out_free;

  // (hi * 2^17 + lo + 2^29) / 2^30
  function automatic logic [35:0] round_mag(input logic [47:0] hi, input logic [47:0] lo);
    logic [65:0] tot;
    tot = (66'(hi) << 17) + 66'(lo) + (66'd1 << 29);
    return tot[65:30];
  endfunction

  // sign a magnitude and clamp to 32-bit two's complement
  function automatic logic [31:0] sat32(input logic [35:0] mag, input logic neg,
                                        input logic deg);
    logic [35:0] negv;
    negv = ~mag + 36'd1;
    if (deg || mag == '0) begin
      return 32'h0000_0000;
    end else if (neg) begin
      return (mag >= 36'h0_8000_0000) ? 32'h8000_0000 : negv[31:0];
    end else begin
      return (mag > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  endfunction

  // one stage of work on a link
  function automatic dcp_pkg::pipe_t stage_step(input int k, input dcp_pkg::pipe_t pi,
                                                input logic [15:0] stiff);
    dcp_pkg::pipe_t p;
    logic [35:0]    remt;
    logic [34:0]    trial;
    logic [48:0]    dsh_r;
    logic [62:0]    dsh_n;
    logic [33:0]    e;
    logic [32:0]    gp;
    logic [49:0]    mp;
    int             j;
    p = pi;
    // offsets and mass sum
    if (k == dcp_pkg::StDiff) begin
      p.dx  = {pi.fx[31], pi.fx} - {pi.gx[31], pi.gx};
      p.dy  = {pi.fy[31], pi.fy} - {pi.gy[31], pi.gy};
      p.sum = {1'b0, pi.w1} + {1'b0, pi.w2};
    end
    // magnitudes, rounded dividends of the mass ratios
    if (k == dcp_pkg::StAbs) begin
      p.xneg = pi.dx[32];
      p.yneg = pi.dy[32];
      p.ax   = pi.dx[32] ? 32'(~pi.dx + 33'd1) : pi.dx[31:0];
      p.ay   = pi.dy[32] ? 32'(~pi.dy + 33'd1) : pi.dy[31:0];
      p.nr1  = 49'({pi.w1, 16'h0000}) + 49'(pi.sum[32:1]);
      p.nr2  = 49'({pi.w2, 16'h0000}) + 49'(pi.sum[32:1]);
      p.r1   = '0;
      p.r2   = '0;
    end
    // squares
    if (k == dcp_pkg::StSquare) begin
      p.sqx = 64'(pi.ax) * 64'(pi.ax);
      p.sqy = 64'(pi.ay) * 64'(pi.ay);
    end
    // radicand
    if (k == dcp_pkg::StRad) begin
      p.rad  = 66'(pi.sqx) + 66'(pi.sqy);
      p.rem  = '0;
      p.root = '0;
    end
    // one bit of the square root
    if (k >= dcp_pkg::StRoot0 && k < dcp_pkg::StRoot0 + dcp_pkg::RootSteps) begin
      remt  = {pi.rem[33:0], pi.rad[65:64]};
      trial = {pi.root, 2'b01};
      p.rad = pi.rad << 2;
      if (remt >= 36'(trial)) begin
        p.rem  = remt - 36'(trial);
        p.root = {pi.root[31:0], 1'b1};
      end else begin
        p.rem  = remt;
        p.root = {pi.root[31:0], 1'b0};
      end
    end
    // one bit of each mass ratio
    if (k >= dcp_pkg::StRatio0 && k < dcp_pkg::StRatio0 + dcp_pkg::RatioSteps) begin
      j     = dcp_pkg::RatioSteps - 1 - (k - dcp_pkg::StRatio0);
      dsh_r = 49'(pi.sum) << j;
      if (pi.nr1 >= dsh_r) begin
        p.nr1 = pi.nr1 - dsh_r;
        p.r1  = {pi.r1[15:0], 1'b1};
      end else begin
        p.r1  = {pi.r1[15:0], 1'b0};
      end
      if (pi.nr2 >= dsh_r) begin
        p.nr2 = pi.nr2 - dsh_r;
        p.r2  = {pi.r2[15:0], 1'b1};
      end else begin
        p.r2  = {pi.r2[15:0], 1'b0};
      end
    end
    // gains with stiffness
    if (k == dcp_pkg::StGain) begin
      gp   = 33'(pi.r1) * 33'(stiff) + 33'd32768;
      p.g1 = gp[32:16];
      gp   = 33'(pi.r2) * 33'(stiff) + 33'd32768;
      p.g2 = gp[32:16];
    end
    // stretch, degenerate check, rounded dividends of the direction
    if (k == dcp_pkg::StErr) begin
      e      = {1'b0, pi.root} - {2'b00, pi.rest};
      p.eneg = e[33];
      p.emag = e[33] ? 33'(~e + 34'd1) : e[32:0];
      p.deg  = (pi.root == '0) || (pi.sum == '0);
      p.nx   = {1'b0, pi.ax, 30'h0} + 63'(pi.root[32:1]);
      p.ny   = {1'b0, pi.ay, 30'h0} + 63'(pi.root[32:1]);
      p.qx   = '0;
      p.qy   = '0;
    end
    // one bit of each direction component
    if (k >= dcp_pkg::StNorm0 && k < dcp_pkg::StNorm0 + dcp_pkg::NormSteps) begin
      j     = dcp_pkg::NormSteps - 1 - (k - dcp_pkg::StNorm0);
      dsh_n = 63'(pi.root) << j;
      if (pi.nx >= dsh_n) begin
        p.nx = pi.nx - dsh_n;
        p.qx = {pi.qx[29:0], 1'b1};
      end else begin
        p.qx = {pi.qx[29:0], 1'b0};
      end
      if (pi.ny >= dsh_n) begin
        p.ny = pi.ny - dsh_n;
        p.qy = {pi.qy[29:0], 1'b1};
      end else begin
        p.qy = {pi.qy[29:0], 1'b0};
      end
    end
    // correction magnitudes along the link
    if (k == dcp_pkg::StMass) begin
      mp   = 50'(pi.g1) * 50'(pi.emag) + 50'd32768;
      p.ma = mp[49:16];
      mp   = 50'(pi.g2) * 50'(pi.emag) + 50'd32768;
      p.mb = mp[49:16];
    end
    // partial products, magnitude split in halves
    if (k == dcp_pkg::StProd) begin
      p.pal_x = 48'(pi.ma[16:0]) * 48'(pi.qx);
      p.pah_x = 48'(pi.ma[33:17]) * 48'(pi.qx);
      p.pal_y = 48'(pi.ma[16:0]) * 48'(pi.qy);
      p.pah_y = 48'(pi.ma[33:17]) * 48'(pi.qy);
      p.pbl_x = 48'(pi.mb[16:0]) * 48'(pi.qx);
      p.pbh_x = 48'(pi.mb[33:17]) * 48'(pi.qx);
      p.pbl_y = 48'(pi.mb[16:0]) * 48'(pi.qy);
      p.pbh_y = 48'(pi.mb[33:17]) * 48'(pi.qy);
    end
    // recombine and round back to Q16.16
    if (k == dcp_pkg::StRound) begin
      p.mag_ax = round_mag(pi.pah_x, pi.pal_x);
      p.mag_ay = round_mag(pi.pah_y, pi.pal_y);
      p.mag_bx = round_mag(pi.pbh_x, pi.pbl_x);
      p.mag_by = round_mag(pi.pbh_y, pi.pbl_y);
    end
    // signs and saturation
    if (k == dcp_pkg::StPack) begin
      p.sax = sat32(pi.mag_ax, !(pi.eneg ^ pi.xneg), pi.deg);
      p.say = sat32(pi.mag_ay, !(pi.eneg ^ pi.yneg), pi.deg);
      p.sbx = sat32(pi.mag_bx, pi.eneg ^ pi.xneg, pi.deg);
      p.sby = sat32(pi.mag_by, pi.eneg ^ pi.yneg, pi.deg);
    end
    return p;
  endfunction

  // stiffness register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= dcp_pkg::StiffReset;
    end else if (stiff_we_i) begin
      stiff_q <= stiff_wdata_i;
    end
  end

  // pipeline moves as long as the skid entry is free
  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;

  // unpack the input beat
  always_comb begin
    pipe_d[0]      = '0;
    pipe_d[0].link = 13'(s_axis_tdata_i[12:0] % dcp_pkg::MaxLinks);
    pipe_d[0].ida  = 12'(s_axis_tdata_i[24:13] % dcp_pkg::MaxParticles);
    pipe_d[0].idb  = 12'(s_axis_tdata_i[36:25] % dcp_pkg::MaxParticles);
    pipe_d[0].fx   = s_axis_tdata_i[68:37];
    pipe_d[0].fy   = s_axis_tdata_i[100:69];
    pipe_d[0].gx   = s_axis_tdata_i[132:101];
    pipe_d[0].gy   = s_axis_tdata_i[164:133];
    pipe_d[0].w1   = s_axis_tdata_i[196:165];
    pipe_d[0].w2   = s_axis_tdata_i[228:197];
    pipe_d[0].rest = s_axis_tdata_i[260:229];
  end

  // stage logic
  for (genvar k = 1; k < NS; k++) begin : g_stage
    assign pipe_d[k] = stage_step(k, pipe_q[k-1], stiff_q);
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid_i};
    end
  end

  // result beat from the last stage
  always_comb begin
    last_res      = '0;
    last_res.deg  = pipe_q[NS-1].deg;
    last_res.data = {3'b000, pipe_q[NS-1].sby, pipe_q[NS-1].sbx, pipe_q[NS-1].idb,
                     pipe_q[NS-1].say, pipe_q[NS-1].sax, pipe_q[NS-1].ida,
                     pipe_q[NS-1].link};
  end

  assign push     = en && vld_q[NS-1];
  assign out_free = !out_vld_q || m_axis_tready_i;

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : last_res;
    end else if (push) begin
      skid_q <= last_res;
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = out_q.data;
  assign m_axis_tuser_o[0] = out_q.deg;

endmodule

### design/dcp_checker.sv
// port checker for the distance constraint projection core and its bind
`timescale 1ns / 1ps
`include "distance_constraint_projection_core_defines.svh"

module dcp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          stiff_we_i,
  input logic [15:0]                   stiff_wdata_i,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [dcp_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [dcp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [0:0]                    m_axis_tuser_o
);

  // a stalled result beat holds
  `DCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // degenerate links carry no correction
  `DCP_ASSERT_SAME(a_deg_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o[56:25] == 32'h0 && m_axis_tdata_o[88:57] == 32'h0 && m_axis_tdata_o[132:101] == 32'h0 && m_axis_tdata_o[164:133] == 32'h0)

  // the two particles move in opposite x directions
  `DCP_ASSERT_SAME(a_x_opposite, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[56:25] != 32'h0 && m_axis_tdata_o[132:101] != 32'h0, m_axis_tdata_o[56] != m_axis_tdata_o[132])

  // the two particles move in opposite y directions
  `DCP_ASSERT_SAME(a_y_opposite, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[88:57] != 32'h0 && m_axis_tdata_o[164:133] != 32'h0, m_axis_tdata_o[88] != m_axis_tdata_o[164])

endmodule

bind distance_constraint_projection_core dcp_checker u_dcp_checker (.*);
